// ----- rtl/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared sizes, codes and the fixed address map of the target selector.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // Number of targets and derived widths
  localparam int TARGET_COUNT = 112;
  localparam int IDX_W        = 7;
  localparam int CNT_W        = $clog2(TARGET_COUNT + 1);
  localparam int NUM_W        = 8;
  localparam int ADDR_W       = 7;
  localparam int BYTE_W       = 8;

  localparam logic [ADDR_W-1:0] BASE_ADDRESS = 7'h08;

  // Request codes
  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_DISABLE = 2'd2,
    REQ_QUERY   = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_INVALID      = 2'd1,
    ST_NO_ACTIVE    = 2'd2,
    ST_CUR_DISABLED = 2'd3
  } status_e;

  // Bus address of a target: base plus index, wrapping in seven bits
  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] idx);
    addr_of = BASE_ADDRESS + ADDR_W'(idx);
  endfunction

endpackage

// ----- rtl/rrts_if.sv -----
// ----------------------------------------------------------------------------
// rrts_req_if / rrts_rsp_if
// Valid/ready channels for requests into and results out of the selector.
// ----------------------------------------------------------------------------
interface rrts_req_if
  import rrts_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [NUM_W-1:0] target_number;

  modport source  (output valid, output req_type, output target_number, input ready);
  modport sink    (input valid, input req_type, input target_number, output ready);
  modport monitor (input valid, input req_type, input target_number, input ready);
endinterface

interface rrts_rsp_if
  import rrts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [IDX_W-1:0]  chosen_index;
  logic [ADDR_W-1:0] chosen_address;
  logic [BYTE_W-1:0] address_byte;

  modport source  (output valid, output status, output chosen_index,
                   output chosen_address, output address_byte, input ready);
  modport sink    (input valid, input status, input chosen_index,
                   input chosen_address, input address_byte, output ready);
  modport monitor (input valid, input status, input chosen_index,
                   input chosen_address, input address_byte, input ready);
endinterface

// ----- rtl/round_robin_target_selector.sv -----
// ----------------------------------------------------------------------------
// round_robin_target_selector
// Round-robin choice of a bus target among those whose enable bit is set.
// ----------------------------------------------------------------------------
// One request is handled at a time. Enable, query and a disable that leaves
// the current target enabled go straight to the state that loads the result.
// Send, and a disable that leaves the current target disabled, run the
// pointer scan: one enable bit is checked per cycle by the shared increment
// and compare step, up to the next enabled target (at most TARGET_COUNT =
// 112 positions ahead, when none is enabled or only the current target is).
// The block is ready for the next request as soon as the result is loaded.
// A finished result waits in the output register; the block accepts the
// next request while it waits, but holds the following result until the
// register is free.
// ----------------------------------------------------------------------------
module round_robin_target_selector
  import rrts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rrts_req_if.sink    req_i,
  rrts_rsp_if.source  rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TARGET_COUNT - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TARGET_COUNT - 1);
  localparam logic [NUM_W-1:0] NUM_MAX  = NUM_W'(TARGET_COUNT);

  state_e                  state_q, state_d;
  logic [TARGET_COUNT-1:0] en_q, en_d;
  logic [IDX_W-1:0]        ptr_q, ptr_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    send_q, send_d;
  status_e                 status_q, status_d;
  logic [IDX_W-1:0]        served_q, served_d;

  logic                    out_valid_q, out_valid_d;
  logic [1:0]              out_status_q, out_status_d;
  logic [IDX_W-1:0]        out_idx_q, out_idx_d;

  logic                    num_ok;
  logic [IDX_W-1:0]        num_idx;
  logic [IDX_W-1:0]        ptr_nxt;
  logic                    accept;
  logic [IDX_W-1:0]        res_idx;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Decode the target number
  assign num_ok  = (req_i.target_number != '0) && (req_i.target_number <= NUM_MAX);
  assign num_idx = IDX_W'(req_i.target_number - NUM_W'(1));

  // Shared step: next position, wrapping
  assign ptr_nxt = (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);

  assign res_idx = send_q ? served_q : ptr_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    en_d         = en_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    send_d       = send_q;
    status_d     = status_q;
    served_d     = served_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;

    // Drop the result once taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          send_d   = 1'b0;
          cnt_d    = '0;
          state_d  = S_DONE;
          case (req_i.req_type)
            REQ_SEND: begin
              send_d   = 1'b1;
              served_d = ptr_q;
              state_d  = S_SCAN;
            end
            REQ_ENABLE: begin
              if (num_ok) begin
                en_d[num_idx] = 1'b1;
              end else begin
                status_d = ST_INVALID;
              end
            end
            REQ_DISABLE: begin
              if (num_ok) begin
                en_d[num_idx] = 1'b0;
              end else begin
                status_d = ST_INVALID;
              end
              if (!en_d[ptr_q]) begin
                state_d = S_SCAN;
              end
            end
            default: begin
              if (!en_q[ptr_q]) begin
                status_d = ST_CUR_DISABLED;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // Advance one candidate per cycle
        ptr_d = ptr_nxt;
        if (en_q[ptr_nxt]) begin
          state_d = S_DONE;
        end else if (cnt_q == LAST_CNT) begin
          if (status_q == ST_OK) begin
            status_d = ST_NO_ACTIVE;
          end
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        // Load the result once the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_idx_d    = res_idx;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      en_q        <= '1;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      en_q        <= en_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    send_q       <= send_d;
    status_q     <= status_d;
    served_q     <= served_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
  end

  // Output channel
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.chosen_index   = out_idx_q;
  assign rsp_o.chosen_address = addr_of(out_idx_q);
  assign rsp_o.address_byte   = {addr_of(out_idx_q), 1'b0};

endmodule

// ----- rtl/rrts_checker.sv -----
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the target selector, bound to the selector module.
// ----------------------------------------------------------------------------
module rrts_checker
  import rrts_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [1:0]        rsp_status_i,
  input logic [IDX_W-1:0]  rsp_index_i,
  input logic [ADDR_W-1:0] rsp_address_i,
  input logic [BYTE_W-1:0] rsp_byte_i
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_index_i))
    else $error("stalled result changed");

  // Go busy after each accepted item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready right after accept");

  // Keep the index in range
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_index_i <= IDX_W'(TARGET_COUNT - 1))
    else $error("index out of range");

  // Match address to index and byte to address
  a_addr_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_address_i == addr_of(rsp_index_i)) &&
                    (rsp_byte_i == {rsp_address_i, 1'b0}))
    else $error("address fields inconsistent");

endmodule

bind round_robin_target_selector rrts_checker u_rrts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_index_i   (rsp_o.chosen_index),
  .rsp_address_i (rsp_o.chosen_address),
  .rsp_byte_i    (rsp_o.address_byte)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin target selector. A scoreboard
// class keeps its own enable mask and pointer, predicts one selection per
// accepted request and checks each returned item field by field. Stimulus
// runs a short directed list, then random episodes: noise, disable and
// enable sweeps over all targets, and bursts focused on a few targets. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb
  import rrts_pkg::*;
;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] address_byte;
  } selection_t;

  // Mirror of the selector state plus the selections still owed by the block
  class target_selector_scoreboard;
    bit               target_on [TARGET_COUNT];
    logic [IDX_W-1:0] cursor;
    selection_t       owed_selections [$];
    int unsigned      errors;

    function new();
      foreach (target_on[i]) target_on[i] = 1'b1;
      cursor = '0;
      errors = 0;
    endfunction

    // Walk forward to the next enabled target; the current one is checked last
    function bit hop_to_next_enabled();
      logic [IDX_W-1:0] probe;
      probe = cursor;
      for (int k = 0; k < TARGET_COUNT; k++) begin
        probe = (probe == IDX_W'(TARGET_COUNT - 1)) ? '0 : probe + IDX_W'(1);
        if (target_on[probe]) begin
          cursor = probe;
          return 1'b1;
        end
      end
      cursor = probe;
      return 1'b0;
    endfunction

    // Predict the selection for one accepted request and queue it
    function void note_request(req_e kind, logic [NUM_W-1:0] number);
      selection_t       sel;
      logic [IDX_W-1:0] reported;
      bit               in_range;
      int               slot;
      in_range = (number >= 1) && (int'(number) <= TARGET_COUNT);
      slot     = int'(number) - 1;
      sel.status = ST_OK;
      reported   = cursor;
      case (kind)
        REQ_SEND: begin
          if (!hop_to_next_enabled()) sel.status = ST_NO_ACTIVE;
        end
        REQ_ENABLE: begin
          if (in_range) target_on[slot] = 1'b1;
          else sel.status = ST_INVALID;
          reported = cursor;
        end
        REQ_DISABLE: begin
          if (in_range) target_on[slot] = 1'b0;
          else sel.status = ST_INVALID;
          if (!target_on[cursor]) begin
            if (!hop_to_next_enabled() && sel.status == ST_OK) sel.status = ST_NO_ACTIVE;
          end
          reported = cursor;
        end
        default: begin
          if (!target_on[cursor]) sel.status = ST_CUR_DISABLED;
        end
      endcase
      sel.index        = reported;
      sel.address      = ADDR_W'(BASE_ADDRESS + reported);
      sel.address_byte = {sel.address, 1'b0};
      owed_selections.push_back(sel);
    endfunction

    // Compare one returned item against the oldest prediction
    function void check_result(logic [1:0] status, logic [IDX_W-1:0] index,
                               logic [ADDR_W-1:0] address, logic [BYTE_W-1:0] address_byte);
      selection_t exp_sel;
      if (owed_selections.size() == 0) begin
        $error("unexpected result: status %0d index %0d", status, index);
        errors++;
        return;
      end
      exp_sel = owed_selections.pop_front();
      if (status !== exp_sel.status) begin
        $error("status: expected %0d, got %0d", exp_sel.status, status);
        errors++;
      end
      if (index !== exp_sel.index) begin
        $error("chosen_index: expected %0d, got %0d", exp_sel.index, index);
        errors++;
      end
      if (address !== exp_sel.address) begin
        $error("chosen_address: expected 0x%0h, got 0x%0h", exp_sel.address, address);
        errors++;
      end
      if (address_byte !== exp_sel.address_byte) begin
        $error("address_byte: expected 0x%0h, got 0x%0h", exp_sel.address_byte, address_byte);
        errors++;
      end
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 1400;

  logic clk_i = 1'b0;
  logic rst_ni;

  rrts_req_if req_if ();
  rrts_rsp_if rsp_if ();

  target_selector_scoreboard scoreboard = new();

  int unsigned items_sent = 0;
  bit          gaps_on    = 1'b1;

  round_robin_target_selector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short idle stretches, a few long ones
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic issue_request(input req_e kind, input int number);
    int unsigned gap;
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.target_number <= NUM_W'(number);
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    scoreboard.note_request(kind, NUM_W'(number));
    items_sent++;
    gap = gaps_on ? idle_cycles() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Enable or disable every target once, from a random start, with sends
  // and queries mixed in
  task automatic sweep_targets(input req_e kind);
    int unsigned start;
    start = $urandom_range(1, TARGET_COUNT);
    for (int i = 0; i < TARGET_COUNT; i++) begin
      issue_request(kind, ((start - 1 + i) % TARGET_COUNT) + 1);
      if ($urandom_range(7) == 0)
        issue_request($urandom_range(1) ? REQ_SEND : REQ_QUERY, $urandom_range(255));
    end
  endtask

  // Request side: reset, directed list, random episodes, drain
  initial begin : request_source
    int unsigned episode_len, pick, base, width, number;
    bit          paused_done;
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_SEND;
    req_if.target_number <= '0;
    paused_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range limits of the target number, every request kind,
    // disabling the current target, pointer moves after send
    issue_request(REQ_QUERY, 255);
    issue_request(REQ_SEND, 0);
    issue_request(REQ_ENABLE, 0);
    issue_request(REQ_ENABLE, 113);
    issue_request(REQ_ENABLE, 255);
    issue_request(REQ_ENABLE, 112);
    issue_request(REQ_ENABLE, 1);
    issue_request(REQ_DISABLE, 2);
    issue_request(REQ_QUERY, 77);
    issue_request(REQ_DISABLE, 0);
    issue_request(REQ_DISABLE, 255);
    issue_request(REQ_DISABLE, 112);
    issue_request(REQ_SEND, 128);
    issue_request(REQ_DISABLE, 4);
    issue_request(REQ_ENABLE, 4);
    issue_request(REQ_SEND, 0);
    issue_request(REQ_SEND, 255);
    issue_request(REQ_ENABLE, 112);
    issue_request(REQ_DISABLE, 1);
    issue_request(REQ_QUERY, 1);

    // Disable everything, then walk the no-active and lone-target cases:
    // query and send of a disabled current target, invalid number beating
    // no active, send when only the current target is enabled
    sweep_targets(REQ_DISABLE);
    issue_request(REQ_QUERY, 0);
    issue_request(REQ_SEND, 0);
    issue_request(REQ_DISABLE, 0);
    issue_request(REQ_DISABLE, 5);
    issue_request(REQ_ENABLE, 40);
    issue_request(REQ_QUERY, 0);
    issue_request(REQ_SEND, 0);
    issue_request(REQ_SEND, 0);
    issue_request(REQ_QUERY, 0);
    issue_request(REQ_DISABLE, 40);
    issue_request(REQ_SEND, 0);
    sweep_targets(REQ_ENABLE);

    while (items_sent < RANDOM_ITEMS) begin
      // Hold off once until the block has returned everything
      if (!paused_done && items_sent >= RANDOM_ITEMS / 2) begin
        paused_done = 1'b1;
        req_if.valid <= 1'b0;
        while (scoreboard.owed_selections.size() != 0) @(posedge clk_i);
      end
      gaps_on     = ($urandom_range(3) != 0);
      episode_len = $urandom_range(20, 40);
      pick        = $urandom_range(99);
      if (pick < 40) begin
        // Noise over the full field ranges
        repeat (episode_len) issue_request(req_e'($urandom_range(3)), $urandom_range(255));
      end else if (pick < 55) begin
        sweep_targets(REQ_DISABLE);
      end else if (pick < 85) begin
        // Focus on a small window of targets, with some out-of-range numbers
        base  = $urandom_range(1, TARGET_COUNT);
        width = $urandom_range(1, 6);
        repeat (episode_len) begin
          pick = $urandom_range(99);
          if (pick < 80) number = ((base - 1 + $urandom_range(width - 1)) % TARGET_COUNT) + 1;
          else if (pick < 90) number = 0;
          else number = $urandom_range(TARGET_COUNT + 1, 255);
          issue_request(req_e'($urandom_range(3)), number);
        end
      end else begin
        sweep_targets(REQ_ENABLE);
      end
    end
    req_if.valid <= 1'b0;

    // Drain, then allow for a full scan before judging
    while (scoreboard.owed_selections.size() != 0) @(posedge clk_i);
    repeat (TARGET_COUNT + 20) @(posedge clk_i);
    if (scoreboard.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: check accepted items and drive ready with random stalls
  initial begin : result_sink
    int unsigned hold_left, seen, phase_left, stall_pct;
    bit          long_hold_done;
    hold_left      = 0;
    seen           = 0;
    phase_left     = 0;
    stall_pct      = 0;
    long_hold_done = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        scoreboard.check_result(rsp_if.status, rsp_if.chosen_index,
                                rsp_if.chosen_address, rsp_if.address_byte);
        seen++;
      end
      // Change the stall rate now and then, including stretches with none
      if (phase_left == 0) begin
        phase_left = $urandom_range(50, 250);
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end else begin
        phase_left--;
      end
      // One long back-pressure stretch so the block fills up
      if (!long_hold_done && seen >= 200) begin
        long_hold_done = 1'b1;
        hold_left      = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        hold_left = idle_cycles();
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rrts_pkg.sv
rtl/rrts_if.sv
rtl/round_robin_target_selector.sv
rtl/rrts_checker.sv
tb/tb.sv
